[rtl/fshs_pkg.sv]
// ---------------------------------------------------------------------------
// fshs_pkg
// Shared types and constants for the fractal simplex height sampler.
// ---------------------------------------------------------------------------
package fshs_pkg;

  localparam int unsigned PERM_AW = 9;
  localparam int unsigned STEP_W  = 24;

  localparam logic [15:0] SKEW_F2   = 16'd23987;
  localparam logic [15:0] UNSKEW_G2 = 16'd13849;
  localparam logic [17:0] OFS_LIMIT = 18'd131072;

  typedef enum logic [1:0] {
    CFG_HEIGHT_LOW  = 2'd0,
    CFG_HEIGHT_SPAN = 2'd1,
    CFG_SAMPLE_STEP = 2'd2,
    CFG_OCTAVES     = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_CELL,
    ST_HASH,
    ST_CORNER,
    ST_ACCUM,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic scale;
    logic skew;
    logic hash;
    logic corner;
    logic accum;
    logic finish;
    logic next_corner;
  } cmd_t;

  typedef struct packed {
    logic fetched;
    logic last_corner;
    logic last_octave;
  } sts_t;

  function automatic logic [15:0] amp_at(input logic [3:0] k);
    logic [15:0] a;
    begin
      case (k)
        4'd0:  a = 16'd42598;
        4'd1:  a = 16'd27689;
        4'd2:  a = 16'd17998;
        4'd3:  a = 16'd11699;
        4'd4:  a = 16'd7604;
        4'd5:  a = 16'd4943;
        4'd6:  a = 16'd3213;
        4'd7:  a = 16'd2088;
        4'd8:  a = 16'd1357;
        4'd9:  a = 16'd882;
        4'd10: a = 16'd573;
        4'd11: a = 16'd373;
        4'd12: a = 16'd242;
        4'd13: a = 16'd157;
        4'd14: a = 16'd102;
        default: a = 16'd67;
      endcase
      return a;
    end
  endfunction

endpackage

[rtl/fshs_ctrl.sv]
// ---------------------------------------------------------------------------
// fshs_ctrl
// Sequencer: per octave scale, cell, then three corners of hash/evaluate.
// ---------------------------------------------------------------------------
module fshs_ctrl
  import fshs_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   go,
  input  logic   zero_oct,
  input  sts_t   sts,
  output cmd_t   cmd,
  output logic   busy,
  output logic   done
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    done      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (go) begin
          cmd.load  = 1'b1;
          state_nxt = zero_oct ? ST_FINISH : ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_CELL;
      end
      ST_CELL: begin
        cmd.skew  = 1'b1;
        state_nxt = ST_HASH;
      end
      ST_HASH: begin
        cmd.hash  = 1'b1;
        state_nxt = sts.fetched ? ST_CORNER : ST_HASH;
      end
      ST_CORNER: begin
        cmd.corner = 1'b1;
        if (sts.last_corner) begin
          state_nxt = ST_ACCUM;
        end else begin
          cmd.next_corner = 1'b1;
          state_nxt       = ST_HASH;
        end
      end
      ST_ACCUM: begin
        cmd.accum = 1'b1;
        state_nxt = sts.last_octave ? ST_FINISH : ST_SCALE;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        done      = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[rtl/fshs_dp.sv]
// ---------------------------------------------------------------------------
// fshs_dp
// Simplex datapath: permutation memory, skew, corner evaluation, octave sum.
// ---------------------------------------------------------------------------
module fshs_dp
  import fshs_pkg::*;
#(
  parameter int unsigned MAX_OCTAVES = 8,
  parameter int unsigned COORD_BITS  = 9
) (
  input  logic                clk,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic                wr_en,
  input  logic [PERM_AW-1:0]  wr_idx,
  input  logic [7:0]          wr_val,
  input  logic [COORD_BITS-1:0] x_in,
  input  logic [COORD_BITS-1:0] y_in,
  input  logic [3:0]          oct_num,
  input  logic [STEP_W-1:0]   step,
  input  logic [7:0]          h_low,
  input  logic [7:0]          h_span,
  output logic [7:0]          height,
  output logic signed [15:0]  noise
);

  localparam int unsigned PW = COORD_BITS + STEP_W + 16;

  logic [7:0] mem [0:(1<<PERM_AW)-1];
  logic [7:0] rd_r;
  logic [PERM_AW-1:0] rd_addr;

  logic [COORD_BITS-1:0] x_r, y_r;
  logic [3:0]  k_r, nk_r;
  logic [PW-1:0] px_r, py_r;
  logic [7:0]  ii_r, jj_r;
  logic signed [19:0] x0_r, y0_r;
  logic        i1_r;
  logic [1:0]  c_r;
  logic        ph_r;
  logic [7:0]  pj_r;
  logic signed [31:0] n_r, tot_r;
  logic [7:0]  h_r;
  logic signed [15:0] nz_r;

  // corner offsets
  logic signed [19:0] cdx, cdy;
  always_comb begin
    case (c_r)
      2'd0: begin cdx = x0_r; cdy = y0_r; end
      2'd1: begin
        cdx = x0_r - (i1_r ? 20'sd65536 : 20'sd0) + $signed({4'd0, UNSKEW_G2});
        cdy = y0_r - (i1_r ? 20'sd0 : 20'sd65536) + $signed({4'd0, UNSKEW_G2});
      end
      default: begin
        cdx = x0_r - 20'sd65536 + $signed({3'd0, UNSKEW_G2, 1'b0});
        cdy = y0_r - 20'sd65536 + $signed({3'd0, UNSKEW_G2, 1'b0});
      end
    endcase
  end

  logic [7:0] oi, oj;
  always_comb begin
    case (c_r)
      2'd0: begin oi = 8'd0; oj = 8'd0; end
      2'd1: begin oi = {7'd0, i1_r}; oj = {7'd0, ~i1_r}; end
      default: begin oi = 8'd1; oj = 8'd1; end
    endcase
  end

  // hash phase 0 reads perm[jj+oj], phase 1 reads perm[ii+oi+pj]
  assign rd_addr = ph_r ? ({1'b0, ii_r} + {1'b0, oi} + {1'b0, rd_r})
                        : ({1'b0, jj_r} + {1'b0, oj});

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_val;
    rd_r <= mem[rd_addr];
  end

  function automatic logic signed [19:0] clampo(input logic signed [19:0] v);
    if (v > $signed({2'b0, OFS_LIMIT})) return $signed({2'b0, OFS_LIMIT});
    if (v < -$signed({2'b0, OFS_LIMIT})) return -$signed({2'b0, OFS_LIMIT});
    return v;
  endfunction

  // falloff spread over both hash phases and the evaluate state
  logic signed [19:0] dx, dy, u, v;
  logic signed [19:0] dx_r, dy_r;
  logic [35:0] dx2, dy2;
  logic signed [37:0] r, r_r;
  logic [37:0] r2, r2_r, r4;
  logic signed [23:0] g;
  logic signed [63:0] rg;
  logic signed [31:0] cn;
  logic [2:0] hh;
  always_comb begin
    hh  = rd_r[2:0];
    dx  = clampo(cdx);
    dy  = clampo(cdy);
    dx2 = 36'($signed(dx) * $signed(dx));
    dy2 = 36'($signed(dy) * $signed(dy));
    r   = 38'sd32768 - $signed({18'd0, dx2[35:16]}) - $signed({18'd0, dy2[35:16]});
    r2  = 38'((r_r[18:0] * r_r[18:0]) >> 16);
    r4  = 38'((r2_r[18:0] * r2_r[18:0]) >> 16);
    u   = hh[2] ? dy_r : dx_r;
    v   = hh[2] ? dx_r : dy_r;
    g   = (hh[0] ? -24'(u) : 24'(u)) + (hh[1] ? -(24'(v) <<< 1) : (24'(v) <<< 1));
    rg  = $signed({26'd0, r4}) * 64'(g);
    cn  = r_r[37] ? 32'sd0 : 32'(rg >>> 16);
  end

  logic [PW+1:0] sum;
  logic [PW+1:0] s;
  logic [PW-15:0] ci, cj;
  logic signed [PW+2:0] t;
  logic signed [19:0] x0c, y0c;
  logic signed [63:0] sc;
  logic signed [31:0] tc;
  logic [39:0] nm;
  always_comb begin
    sum = {2'b0, px_r} + {2'b0, py_r};
    s   = (PW+2)'((sum * SKEW_F2) >> 16);
    ci  = (PW-14)'(({2'b0, px_r} + s) >> 16);
    cj  = (PW-14)'(({2'b0, py_r} + s) >> 16);
    t   = $signed((PW+3)'(({1'b0, ci} + {1'b0, cj}) * UNSKEW_G2));
    x0c = 20'($signed({1'b0, px_r}) - $signed({1'b0, ci, 16'd0}) + t);
    y0c = 20'($signed({1'b0, py_r}) - $signed({1'b0, cj, 16'd0}) + t);
    sc  = 64'(n_r) * 64'sd40 * $signed({48'd0, amp_at(k_r)});
    tc  = (tot_r > 32'sd65536) ? 32'sd65536 :
          (tot_r < -32'sd65536) ? -32'sd65536 : tot_r;
    nm  = 40'(32'(tc + 32'sd65536) >> 1) * {32'd0, h_span};
  end

  assign sts.fetched     = ph_r;
  assign sts.last_corner = (c_r == 2'd2) && ph_r;
  assign sts.last_octave = (k_r + 4'd1 == nk_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r   <= x_in;
      y_r   <= y_in;
      k_r   <= '0;
      nk_r  <= ({28'd0, oct_num} > MAX_OCTAVES) ? 4'(MAX_OCTAVES) : oct_num;
      tot_r <= '0;
    end
    if (cmd.scale) begin
      px_r <= PW'(({16'd0, x_r} * step << k_r) >> 8);
      py_r <= PW'(({16'd0, y_r} * step << k_r) >> 8);
      n_r  <= '0;
      c_r  <= '0;
      ph_r <= 1'b0;
    end
    if (cmd.skew) begin
      ii_r <= ci[7:0];
      jj_r <= cj[7:0];
      x0_r <= x0c;
      y0_r <= y0c;
      i1_r <= x0c > y0c;
    end
    if (cmd.hash) begin
      ph_r <= 1'b1;
      dx_r <= dx;
      dy_r <= dy;
      r_r  <= r;
      r2_r <= r2;
    end
    if (cmd.corner) begin
      n_r  <= n_r + cn;
      ph_r <= 1'b0;
    end
    if (cmd.next_corner) c_r <= c_r + 2'd1;
    if (cmd.accum) begin
      tot_r <= tot_r + 32'(sc >>> 16);
      k_r   <= k_r + 4'd1;
    end
    if (cmd.finish) begin
      h_r  <= h_low + nm[23:16];
      nz_r <= 16'(tc >>> 2);
    end
  end

  assign height = h_r;
  assign noise  = nz_r;

endmodule

[rtl/fractal_simplex_height_sample_core.sv]
// ---------------------------------------------------------------------------
// fractal_simplex_height_sample_core
// Fractal 2D simplex height sampler with a 512-byte permutation memory.
// ---------------------------------------------------------------------------
// A write word (action 0) stores one permutation byte and gives no result.
// A sample word runs over its octaves, capped at MAX_OCTAVES: each octave
// uses one scale step, one cell step, two memory reads and an evaluate per
// corner over three corners, and an accumulate; results strobe on out_valid
// for one cycle and cannot be stalled. Unwritten table entries read as
// undefined.
module fractal_simplex_height_sample_core
  import fshs_pkg::*;
#(
  parameter int unsigned MAX_OCTAVES = 8,
  parameter int unsigned COORD_BITS  = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_action,
  input  logic [8:0]         in_perm_index,
  input  logic [7:0]         in_perm_value,
  input  logic [8:0]         in_x_coord,
  input  logic [8:0]         in_y_coord,
  output logic               out_valid,
  output logic [7:0]         out_height_out,
  output logic signed [15:0] out_noise_value,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  logic [7:0]  low_r, span_r;
  logic [23:0] step_r;
  logic [3:0]  oct_r;
  cmd_t cmd;
  sts_t sts;
  logic acc, ctl_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= 8'd2;
      span_r <= 8'd24;
      step_r <= 24'd40960;
      oct_r  <= 4'd4;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HEIGHT_LOW:  low_r  <= cfg_data[7:0];
        CFG_HEIGHT_SPAN: span_r <= cfg_data[7:0];
        CFG_SAMPLE_STEP: step_r <= cfg_data;
        CFG_OCTAVES:     oct_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign acc  = start && !busy;
  assign busy = ctl_busy;

  fshs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .go(acc && in_action), .zero_oct(oct_r == 4'd0),
    .sts(sts), .cmd(cmd), .busy(ctl_busy), .done(out_valid)
  );

  fshs_dp #(.MAX_OCTAVES(MAX_OCTAVES), .COORD_BITS(COORD_BITS)) u_dp (
    .clk(clk), .cmd(cmd), .sts(sts),
    .wr_en(acc && !in_action), .wr_idx(in_perm_index), .wr_val(in_perm_value),
    .x_in(COORD_BITS'(in_x_coord)), .y_in(COORD_BITS'(in_y_coord)),
    .oct_num(oct_r), .step(step_r), .h_low(low_r), .h_span(span_r),
    .height(out_height_out), .noise(out_noise_value)
  );

  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without work");
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result");
  a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_action) |=> !busy) else $error("write went busy");

endmodule
